>>> rtl/bpps_pkg.sv
// bpps_pkg: shared types, constants and helpers for the bouncing particle pool
// used by the channel interfaces, the controller, the datapath and the top level
package bpps_pkg;

    localparam int NUM_DOTS = 16;
    localparam int IDX_W    = (NUM_DOTS > 1) ? $clog2(NUM_DOTS) : 1;

    localparam int COORD_W    = 9;
    localparam int SPEED_W    = 14;
    localparam int HEIGHT_W   = 20;
    localparam int SLOT_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DOTS - 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_STEP   = 3'd4;

    localparam logic [9:0]         RST_SCREEN_WIDTH  = 10'd320;
    localparam logic [9:0]         RST_SCREEN_HEIGHT = 10'd200;
    localparam logic [7:0]         RST_GRAVITY       = 8'd10;
    localparam logic [9:0]         RST_STOP_SPEED    = 10'd30;
    localparam logic [3:0]         RST_CURSOR_STEP   = 4'd2;
    localparam logic [COORD_W-1:0] RST_CURSOR_COL    = 9'd160;
    localparam logic [COORD_W-1:0] RST_CURSOR_ROW    = 9'd100;

    // 9/10 by reciprocal: q = (m * 9 * ceil(2^20 / 10)) >> 20, exact for m <= 8192
    localparam logic [33:0] DIV10_MUL   = 34'd943722;
    localparam int          DIV10_SHIFT = 20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CURSOR,
        ST_SPAWN,
        ST_WALK,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic arrow_left;
        logic arrow_right;
        logic key_up;
        logic arrow_down;
        logic key_drop;
    } t_keys;

    typedef struct packed {
        logic             load;
        logic             cursor;
        logic             spawn;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic adv;
        logic busy;
    } t_dp_status;

    // width and height registers: 0 acts as 1, above 512 acts as 512
    function automatic logic [9:0] eff_dim(input logic [9:0] v);
        logic [9:0] r;
        if (v == 10'd0) begin
            r = 10'd1;
        end else if (v > 10'd512) begin
            r = 10'd512;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> rtl/bpps_if.sv
// bpps_if: valid/ready channel interfaces for key words, result words and config writes
// depends on bpps_pkg
interface bpps_in_if;
    import bpps_pkg::*;
    logic valid;
    logic ready;
    logic arrow_left;
    logic arrow_right;
    logic key_up;
    logic arrow_down;
    logic key_drop;

    modport source (output valid, arrow_left, arrow_right, key_up, arrow_down, key_drop,
                    input ready);
    modport sink (input valid, arrow_left, arrow_right, key_up, arrow_down, key_drop,
                  output ready);
endinterface

interface bpps_out_if;
    import bpps_pkg::*;
    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  slot;
    logic               alive;
    logic [COORD_W-1:0] dot_col;
    logic [COORD_W-1:0] dot_row;
    logic [COORD_W-1:0] pointer_col;
    logic [COORD_W-1:0] pointer_row;
    logic               last;

    modport source (output valid, slot, alive, dot_col, dot_row, pointer_col, pointer_row,
                    last, input ready);
    modport sink (input valid, slot, alive, dot_col, dot_row, pointer_col, pointer_row,
                  last, output ready);
endinterface

interface bpps_cfg_if;
    import bpps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/bouncing_particle_pool_step.sv
// bouncing_particle_pool_step: one key word in, one result word per dot slot out
// first result: after cursor and spawn, via the read, move, bounce and result registers
// key words: one at a time, accepted only in idle after cursor, spawn, the slot walk and drain;
//   the walk reads one slot per cycle from the dot stores unless the result side stalls
// reset: synchronous active-low i_rst_n; cursor to 160/100, no active dots, config to defaults
module bouncing_particle_pool_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpps_in_if.sink     i_in,
    bpps_cfg_if.sink    i_cfg,
    bpps_out_if.source  o_out
);
    import bpps_pkg::*;

    t_keys      keys;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    assign keys.arrow_left  = i_in.arrow_left;
    assign keys.arrow_right = i_in.arrow_right;
    assign keys.key_up      = i_in.key_up;
    assign keys.arrow_down  = i_in.arrow_down;
    assign keys.key_drop    = i_in.key_drop;

    bpps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    bpps_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_keys   (keys),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .i_cfg    (i_cfg),
        .o_out    (o_out)
    );

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !dp_status.busy)
        else $error("key word accepted while slot pipeline busy");

    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |-> (o_out.slot == SLOT_W'(NUM_DOTS - 1)))
        else $error("last flag on wrong slot");

    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.alive) |-> (o_out.dot_col == '0 && o_out.dot_row == '0))
        else $error("inactive slot reports nonzero position");

    a_read_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.rd_en |=> ($past(dp_status.adv) && dp_status.busy))
        else $error("slot read issued while pipeline stalled");

endmodule

>>> rtl/bpps_ctrl.sv
// bpps_ctrl: tick sequencer; cursor update, spawn, slot walk, pipeline drain
// depends on bpps_pkg; drives the datapath through t_dp_cmd
module bpps_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  bpps_pkg::t_dp_status  i_status,
    output bpps_pkg::t_dp_cmd     o_cmd
);
    import bpps_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_cmd        = '0;
        o_cmd.rd_idx = r_idx;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CURSOR;
                end
            end
            ST_CURSOR: begin
                o_cmd.cursor = 1'b1;
                n_state      = ST_SPAWN;
            end
            ST_SPAWN: begin
                o_cmd.spawn = 1'b1;
                n_idx       = '0;
                n_state     = ST_WALK;
            end
            ST_WALK: begin
                if (i_status.adv) begin
                    o_cmd.rd_en = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/bpps_datapath.sv
// bpps_datapath: config registers, cursor, dot stores and the per-slot update pipeline
// depends on bpps_pkg and bpps_if; controlled by bpps_ctrl
module bpps_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bpps_pkg::t_keys       i_keys,
    input  bpps_pkg::t_dp_cmd     i_cmd,
    output bpps_pkg::t_dp_status  o_status,
    bpps_cfg_if.sink              i_cfg,
    bpps_out_if.source            o_out
);
    import bpps_pkg::*;

    // config
    logic [9:0] r_width, r_height, r_stop;
    logic [7:0] r_gravity;
    logic [3:0] r_step;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_SCREEN_WIDTH;
            r_height  <= RST_SCREEN_HEIGHT;
            r_gravity <= RST_GRAVITY;
            r_stop    <= RST_STOP_SPEED;
            r_step    <= RST_CURSOR_STEP;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SCREEN_WIDTH:  r_width   <= i_cfg.data;
                REG_SCREEN_HEIGHT: r_height  <= i_cfg.data;
                REG_GRAVITY:       r_gravity <= i_cfg.data[7:0];
                REG_STOP_SPEED:    r_stop    <= i_cfg.data;
                REG_CURSOR_STEP:   r_step    <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

    logic [9:0]         w_eff, h_eff;
    logic [COORD_W-1:0] w_max, bottom;

    assign w_eff  = eff_dim(r_width);
    assign h_eff  = eff_dim(r_height);
    assign w_max  = COORD_W'(w_eff - 10'd1);
    assign bottom = COORD_W'(h_eff - 10'd1);

    // cursor and drop edge
    t_keys              r_keys;
    logic [COORD_W-1:0] r_col, r_row, n_col, n_row;
    logic               r_drop_prev, r_spawn_req;
    logic signed [10:0] step_s, col_s, row_s;

    always_comb begin
        step_s = $signed({7'b0, r_step});
        col_s  = $signed({2'b00, r_col});
        row_s  = $signed({2'b00, r_row});
        if (r_keys.arrow_left)  col_s = col_s - step_s;
        if (r_keys.arrow_right) col_s = col_s + step_s;
        if (r_keys.key_up)      row_s = row_s - step_s;
        if (r_keys.arrow_down)  row_s = row_s + step_s;
        if (col_s < 11'sd0) begin
            n_col = '0;
        end else if (col_s > $signed({2'b00, w_max})) begin
            n_col = w_max;
        end else begin
            n_col = col_s[COORD_W-1:0];
        end
        if (row_s < 11'sd0) begin
            n_row = '0;
        end else if (row_s > $signed({2'b00, bottom})) begin
            n_row = bottom;
        end else begin
            n_row = row_s[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= RST_CURSOR_COL;
            r_row       <= RST_CURSOR_ROW;
            r_drop_prev <= 1'b0;
            r_spawn_req <= 1'b0;
        end else if (i_cmd.cursor) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_drop_prev <= r_keys.key_drop;
            r_spawn_req <= r_keys.key_drop & ~r_drop_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_keys <= i_keys;
        end
    end

    // free slot search, lowest index wins
    logic [NUM_DOTS-1:0] r_active;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_DOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // dot stores
    logic [COORD_W-1:0]         mem_x [NUM_DOTS];
    logic signed [HEIGHT_W-1:0] mem_h [NUM_DOTS];
    logic signed [SPEED_W-1:0]  mem_v [NUM_DOTS];

    logic adv;
    assign adv = ~o_out.valid | o_out.ready;

    // read stage
    logic                       r_r_valid, r_r_act;
    logic [IDX_W-1:0]           r_r_idx;
    logic [COORD_W-1:0]         r_r_x;
    logic signed [HEIGHT_W-1:0] r_r_h;
    logic signed [SPEED_W-1:0]  r_r_v;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_r_idx <= i_cmd.rd_idx;
            r_r_act <= r_active[i_cmd.rd_idx];
            r_r_x   <= mem_x[i_cmd.rd_idx];
            r_r_h   <= mem_h[i_cmd.rd_idx];
            r_r_v   <= mem_v[i_cmd.rd_idx];
        end
    end

    // gravity, move, floor test
    logic signed [SPEED_W:0]    v_sum;
    logic signed [HEIGHT_W:0]   y_sum;
    logic signed [SPEED_W-1:0]  v_a;
    logic signed [HEIGHT_W-1:0] y_a;
    logic                       hit_a;

    always_comb begin
        v_sum = $signed({r_r_v[SPEED_W-1], r_r_v}) + $signed({7'b0, r_gravity});
        if (v_sum > 15'sd8191) begin
            v_a = 14'sd8191;
        end else if (v_sum < -15'sd8192) begin
            v_a = -14'sd8192;
        end else begin
            v_a = v_sum[SPEED_W-1:0];
        end
        y_sum = $signed({r_r_h[HEIGHT_W-1], r_r_h}) + $signed({{7{v_a[SPEED_W-1]}}, v_a});
        if (y_sum > 21'sd524287) begin
            y_a = 20'sd524287;
        end else if (y_sum < -21'sd524288) begin
            y_a = -20'sd524288;
        end else begin
            y_a = y_sum[HEIGHT_W-1:0];
        end
        if (!y_a[HEIGHT_W-1]) begin
            hit_a = {1'b0, y_a[18:8]} >= {3'b000, bottom};
        end else begin
            hit_a = (bottom == '0) && (&y_a[19:8]) && (y_a[7:0] != 8'd0);
        end
    end

    logic                       r_a_valid, r_a_act, r_a_hit;
    logic [IDX_W-1:0]           r_a_idx;
    logic [COORD_W-1:0]         r_a_x;
    logic signed [HEIGHT_W-1:0] r_a_y;
    logic signed [SPEED_W-1:0]  r_a_v;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_idx <= r_r_idx;
            r_a_act <= r_r_act;
            r_a_hit <= hit_a;
            r_a_x   <= r_r_x;
            r_a_y   <= y_a;
            r_a_v   <= v_a;
        end
    end

    // bounce: magnitude times nine tenths
    logic [SPEED_W-1:0] mag_b;
    logic [33:0]        prod_b;

    assign mag_b  = r_a_v[SPEED_W-1] ? SPEED_W'(-r_a_v) : SPEED_W'(r_a_v);
    assign prod_b = 34'(mag_b) * DIV10_MUL;

    logic                       r_b_valid, r_b_act, r_b_hit;
    logic [IDX_W-1:0]           r_b_idx;
    logic [COORD_W-1:0]         r_b_x;
    logic signed [HEIGHT_W-1:0] r_b_y;
    logic signed [SPEED_W-1:0]  r_b_v;
    logic [SPEED_W-1:0]         r_b_q;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_idx <= r_a_idx;
            r_b_act <= r_a_act;
            r_b_hit <= r_a_hit;
            r_b_x   <= r_a_x;
            r_b_y   <= r_a_y;
            r_b_v   <= r_a_v;
            r_b_q   <= prod_b[DIV10_SHIFT+SPEED_W-1:DIV10_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_r_valid <= i_cmd.rd_en;
            r_a_valid <= r_r_valid;
            r_b_valid <= r_a_valid;
        end
    end

    // final speed, retire, write back
    logic signed [SPEED_W-1:0]  v_new;
    logic signed [HEIGHT_W-1:0] y_new;
    logic                       retire, alive;
    logic [COORD_W-1:0]         row_new;

    always_comb begin
        if (r_b_hit) begin
            v_new = r_b_v[SPEED_W-1] ? $signed(r_b_q) : -$signed(r_b_q);
            y_new = $signed({3'b000, bottom, 8'b0});
        end else begin
            v_new = r_b_v;
            y_new = r_b_y;
        end
        retire = r_b_hit && (r_b_q < {4'b0, r_stop});
        alive  = r_b_act && !retire;
        if (y_new[HEIGHT_W-1]) begin
            row_new = '0;
        end else if (|y_new[18:17]) begin
            row_new = 9'd511;
        end else begin
            row_new = y_new[16:8];
        end
    end

    logic                       spawn_we, wb_we, mem_we;
    logic [IDX_W-1:0]           wr_idx;
    logic [COORD_W-1:0]         wr_x;
    logic signed [HEIGHT_W-1:0] wr_h;
    logic signed [SPEED_W-1:0]  wr_v;

    assign spawn_we = i_cmd.spawn && r_spawn_req && free_found;
    assign wb_we    = adv && r_b_valid && r_b_act;
    assign mem_we   = spawn_we | wb_we;

    always_comb begin
        if (spawn_we) begin
            wr_idx = free_idx;
            wr_x   = r_col;
            wr_h   = $signed({3'b000, r_row, 8'b0});
            wr_v   = '0;
        end else begin
            wr_idx = r_b_idx;
            wr_x   = r_b_x;
            wr_h   = y_new;
            wr_v   = v_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_x[wr_idx] <= wr_x;
            mem_h[wr_idx] <= wr_h;
            mem_v[wr_idx] <= wr_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else begin
            if (spawn_we) begin
                r_active[free_idx] <= 1'b1;
            end
            if (wb_we && retire) begin
                r_active[r_b_idx] <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out.valid <= 1'b0;
        end else if (adv) begin
            o_out.valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_b_valid) begin
            o_out.slot        <= SLOT_W'(r_b_idx);
            o_out.alive       <= alive;
            o_out.dot_col     <= alive ? r_b_x : '0;
            o_out.dot_row     <= alive ? row_new : '0;
            o_out.pointer_col <= r_col;
            o_out.pointer_row <= r_row;
            o_out.last        <= (r_b_idx == LAST_IDX);
        end
    end

    assign o_status.adv  = adv;
    assign o_status.busy = r_r_valid | r_a_valid | r_b_valid;

endmodule
